// ===== design/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
`default_nettype none
package ple_pkg;

  localparam int unsigned CapacityDef = 16;

  localparam int unsigned KindW  = 2;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 5;
  localparam int unsigned FoundW = 4;
  localparam int unsigned CountW = 5;

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_e;

  // shift command broadcast to every cell, already qualified by acceptance
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_op_t;

endpackage
`default_nettype wire

// ===== design/ple_req_if.sv =====
// Request channel: one list operation per accepted request.
`default_nettype none
interface ple_req_if;
  import ple_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         kind;
  logic signed [ValueW-1:0] value;
  logic [PosW-1:0]          position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface
`default_nettype wire

// ===== design/ple_rsp_if.sv =====
// Response channel: status, removed value, found position and count.
`default_nettype none
interface ple_rsp_if;
  import ple_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     status;
  logic signed [ValueW-1:0] removed_value;
  logic [FoundW-1:0]        found_position;
  logic [CountW-1:0]        count;

  modport source (output valid, status, removed_value, found_position, count, input ready);
  modport sink   (input valid, status, removed_value, found_position, count, output ready);
endinterface
`default_nettype wire

// ===== design/ple_cell.sv =====
// One list slot: holds an entry, shifts with its neighbors, compares on search.
`default_nettype none
module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 5
) (
  input  wire logic                     clk_i,
  input  wire cell_op_t                 op_i,
  input  wire logic [PW-1:0]            pos_i,
  input  wire logic [PW-1:0]            count_i,
  input  wire logic signed [ValueW-1:0] value_i,
  input  wire logic signed [ValueW-1:0] left_i,
  input  wire logic signed [ValueW-1:0] right_i,
  input  wire logic                     hit_i,
  output logic signed [ValueW-1:0]      entry_o,
  output logic                          hit_o,
  output logic                          first_o,
  output logic signed [ValueW-1:0]      pick_o
);

  localparam logic [PW-1:0] MyIdx = PW'(IDX);

  logic signed [ValueW-1:0] entry_q, entry_d;
  logic                     live, match;

  assign live    = MyIdx < count_i;
  assign match   = live && (entry_q == value_i);
  assign first_o = match && !hit_i;
  assign hit_o   = hit_i || match;
  assign pick_o  = (MyIdx == pos_i) ? entry_q : '0;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (op_i.ins) begin
      if (MyIdx == pos_i) begin
        entry_d = value_i;
      end else if (MyIdx > pos_i) begin
        entry_d = left_i;
      end
    end else if (op_i.rem && (MyIdx >= pos_i)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

// ===== design/positional_list_engine_unit.sv =====
// A request's response is registered at the same clock edge that accepts the request.
// Throughput: one request per cycle unless the output stalls; every operation completes in the single
// cell-chain pass. The response register frees whenever downstream takes it, so requests stream.
// Reset clears the entry count and the response valid; slot contents stay undefined,
// which is harmless since only slots below the count are ever read.
`default_nettype none
module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ple_req_if.sink   req_i,
  ple_rsp_if.source rsp_o
);

  // count width holds 0..CAPACITY; compare width covers both the count and the request position
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > PosW) ? CW : PosW;
  localparam int unsigned IW = $clog2(CAPACITY);

  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  logic [CW-1:0] count_q, count_d;
  logic          valid_q;
  logic          status_q;
  logic signed [ValueW-1:0] removed_q;
  logic [FoundW-1:0]        found_q;
  logic [CountW-1:0]        cnt_out_q;

  logic          accept;
  logic [PW-1:0] pos_x, cnt_x;
  logic          ins_ok, rem_ok, srch_ok;
  cell_op_t      op;

  // cell chain wiring: entries flow both ways for shifting, hit flag ripples up
  logic signed [ValueW-1:0] entry [CAPACITY];
  logic signed [ValueW-1:0] pick  [CAPACITY];
  logic [CAPACITY:0]        hit;
  logic [CAPACITY-1:0]      first;

  logic signed [ValueW-1:0] removed_val;
  logic [IW-1:0]            found_idx;
  logic [31:0]              found_wide, count_wide;

  assign req_i.ready = !valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign pos_x = PW'(req_i.position);
  assign cnt_x = PW'(count_q);

  // insert may land at the end but never beyond it and needs a free slot; remove needs an occupied slot
  assign ins_ok  = (req_i.kind == KIND_INSERT) && (pos_x <= cnt_x) && (count_q < CapCount);
  assign rem_ok  = (req_i.kind == KIND_REMOVE) && (pos_x < cnt_x);
  assign srch_ok = (req_i.kind == KIND_SEARCH) && hit[CAPACITY];

  assign op.ins = accept && ins_ok;
  assign op.rem = accept && rem_ok;

  assign hit[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ValueW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry[g+1];
    end

    ple_cell #(
      .IDX (g),
      .PW  (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .pos_i   (pos_x),
      .count_i (cnt_x),
      .value_i (req_i.value),
      .left_i  (left_w),
      .right_i (right_w),
      .hit_i   (hit[g]),
      .entry_o (entry[g]),
      .hit_o   (hit[g+1]),
      .first_o (first[g]),
      .pick_o  (pick[g])
    );
  end

  // at most one cell picks and at most one cell is the first match, so OR-merge them
  always_comb begin
    removed_val = '0;
    found_idx   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed_val = removed_val | pick[i];
      found_idx   = found_idx | (first[i] ? IW'(i) : IW'(0));
    end
  end

  always_comb begin
    count_d = count_q;
    if (op.ins) begin
      count_d = count_q + CW'(1);
    end else if (op.rem) begin
      count_d = count_q - CW'(1);
    end
  end

  assign found_wide = 32'(found_idx);
  assign count_wide = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // response payload, loaded on every accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= !(ins_ok || rem_ok || srch_ok);
      removed_q <= rem_ok ? removed_val : '0;
      found_q   <= srch_ok ? found_wide[FoundW-1:0] : '0;
      cnt_out_q <= count_wide[CountW-1:0];
    end
  end

  assign rsp_o.valid          = valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.removed_value  = removed_q;
  assign rsp_o.found_position = found_q;
  assign rsp_o.count          = cnt_out_q;

endmodule
`default_nettype wire
